FILE: sv/cgf_pkg.sv
// ----------------------------------------------------------------------------
// Calibration table gap fill: shared definitions
// Operation codes, controller states and the command and status bundles
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package cgf_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_FILL  = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_START,
      ST_BOOT,
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SEG,
      ST_RD_A,
      ST_RD_B,
      ST_MUL,
      ST_DIV_LD,
      ST_DIV,
      ST_WR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic wr_req;
      logic rd_issue;
      logic clr_start;
      logic clr_step;
      logic scan_init;
      logic scan_rd;
      logic scan_next;
      logic scan_take;
      logic seg_pair;
      logic seg_end;
      logic rng_lead;
      logic rng_gap;
      logic rd_a;
      logic rd_b;
      logic mul;
      logic div_ld;
      logic div_step;
      logic wr_fill;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   mark;
      logic   have_prev;
      logic   lead;
      logic   gap_ne;
      logic   j_last;
      logic   clr_last;
      logic   fill_last;
      logic   div_last;
      logic   rsp_free;
   } sts_type;

endpackage

FILE: sv/cgf_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one table operation per transaction.
// ----------------------------------------------------------------------------
interface cgf_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [7:0]         channel;
   logic [2:0]         column;
   logic signed [15:0] gain_value;

   modport source (output valid, operation, channel, column, gain_value, input ready);
   modport sink   (input valid, operation, channel, column, gain_value, output ready);
endinterface

FILE: sv/cgf_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that returns one completion per request.
// ----------------------------------------------------------------------------
interface cgf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] read_value;
   logic               entry_marked;
   logic               done_res;

   modport source (output valid, read_value, entry_marked, done_res, input ready);
   modport sink   (input valid, read_value, entry_marked, done_res, output ready);
endinterface

FILE: sv/cgf_dp.sv
// ----------------------------------------------------------------------------
// Calibration table gap fill: datapath
// Gain table and mark memories, scan and fill counters, the multiplier,
// a restoring divider one quotient bit per cycle, and the response register.
// ----------------------------------------------------------------------------
module cgf_dp #(
   parameter int CHANNELS = 256,
   parameter int COLUMNS  = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  cgf_pkg::cmd_type cmd,
   output cgf_pkg::sts_type sts,
   cgf_req_if.sink          req_ch,
   cgf_rsp_if.source        rsp_ch
);

   localparam int CW   = $clog2(CHANNELS);
   localparam int COLW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int AW   = $clog2(CHANNELS * COLUMNS);
   localparam int DW   = 17;
   localparam int XW   = CW + 1;
   localparam int PW   = DW + XW;
   localparam int NW   = $clog2(PW);

   logic [15:0] tab_mem [CHANNELS * COLUMNS];
   logic        mark_mem [CHANNELS];

   cgf_pkg::op_type op_ff, op_in;
   logic [7:0]  ch_ff, ch_in;
   logic [2:0]  col_ff, col_in;
   logic [15:0] val_ff, val_in;
   logic [CW-1:0] j_ff, j_in, prev_ff, prev_in, a_ff, a_in, b_ff, b_in;
   logic [CW-1:0] x_ff, x_in, last_ff, last_in;
   logic [COLW-1:0] c_ff, c_in;
   logic have_prev_ff, have_prev_in, lead_ff, lead_in, gap_done_ff, gap_done_in;
   logic [15:0] ya_ff, ya_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [PW-1:0] dvd_ff, dvd_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic neg_ff, neg_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [15:0] tab_q_ff;
   logic        mark_q_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_value_ff, rsp_value_in;
   logic        rsp_mark_ff, rsp_mark_in;

   logic idx_ok, c_last, adv;
   logic [AW-1:0] req_addr, t_waddr, t_raddr;
   logic t_we, t_re, m_we, m_re, m_wdata;
   logic [15:0] t_wdata, sat_val;
   logic [CW-1:0] m_waddr, m_raddr, span;
   logic signed [DW-1:0] diff;
   logic signed [XW-1:0] dx;
   logic signed [PW-1:0] prod_c;
   logic [CW:0] rem_s;
   logic ge;
   logic signed [PW:0] qs;
   logic signed [PW+1:0] sum;
   logic in_range;

   function automatic logic [AW-1:0] tab_addr(input logic [CW-1:0] ch,
                                             input logic [COLW-1:0] c);
      return AW'(ch) * AW'(COLUMNS) + AW'(c);
   endfunction

   always_comb begin
      idx_ok   = (32'(ch_ff) < CHANNELS) && (32'(col_ff) < COLUMNS);
      req_addr = tab_addr(CW'(ch_ff), COLW'(col_ff));
      c_last   = (c_ff == COLW'(COLUMNS - 1));
      adv      = cmd.clr_step | cmd.wr_fill;
      span     = b_ff - a_ff;

      // Fill arithmetic: ya + (yb - ya) * (x - a) / (b - a).
      diff   = $signed({tab_q_ff[15], tab_q_ff}) - $signed({ya_ff[15], ya_ff});
      dx     = $signed({1'b0, x_ff}) - $signed({1'b0, a_ff});
      prod_c = diff * dx;
      rem_s  = {rem_ff, dvd_ff[PW-1]};
      ge     = (rem_s >= {1'b0, span});
      qs     = neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});
      sum    = $signed({{(PW+2-16){ya_ff[15]}}, ya_ff}) + $signed({qs[PW], qs});
      in_range = (&sum[PW+1:15]) | ~(|sum[PW+1:15]);
      sat_val  = in_range ? sum[15:0] : (sum[PW+1] ? 16'h8000 : 16'h7FFF);

      t_we    = cmd.clr_step | cmd.wr_fill | (cmd.wr_req & idx_ok);
      t_waddr = cmd.wr_req ? req_addr : tab_addr(x_ff, c_ff);
      t_wdata = cmd.clr_step ? 16'h0000 : (cmd.wr_req ? val_ff : sat_val);
      m_we    = t_we;
      m_waddr = cmd.wr_req ? CW'(ch_ff) : x_ff;
      m_wdata = ~cmd.clr_step;
      t_re    = cmd.rd_issue | cmd.rd_a | cmd.rd_b;
      t_raddr = cmd.rd_issue ? req_addr : tab_addr(cmd.rd_a ? a_ff : b_ff, c_ff);
      m_re    = cmd.rd_issue | cmd.scan_rd;
      m_raddr = cmd.rd_issue ? CW'(ch_ff) : j_ff;
   end

   always_comb begin
      op_in = op_ff;
      ch_in = ch_ff;
      col_in = col_ff;
      val_in = val_ff;
      if (cmd.latch_req) begin
         op_in  = cgf_pkg::op_type'(req_ch.operation);
         ch_in  = req_ch.channel;
         col_in = req_ch.column;
         val_in = req_ch.gain_value;
      end

      j_in = j_ff;
      prev_in = prev_ff;
      a_in = a_ff;
      b_in = b_ff;
      have_prev_in = have_prev_ff;
      lead_in = lead_ff;
      gap_done_in = gap_done_ff;
      if (cmd.scan_init) begin
         j_in = '0;
         have_prev_in = 1'b0;
         lead_in = 1'b0;
      end
      if (cmd.scan_next) j_in = j_ff + 1'b1;
      if (cmd.scan_take) begin
         prev_in = j_ff;
         have_prev_in = 1'b1;
         lead_in = (j_ff != '0);
      end
      if (cmd.seg_pair) begin
         a_in = prev_ff;
         b_in = j_ff;
         gap_done_in = 1'b0;
      end
      if (cmd.seg_end) prev_in = j_ff;

      x_in = x_ff;
      c_in = c_ff;
      last_in = last_ff;
      if (cmd.clr_start) begin
         x_in = '0;
         c_in = '0;
      end
      if (cmd.rng_lead) begin
         x_in = '0;
         c_in = '0;
         last_in = a_ff - 1'b1;
         lead_in = 1'b0;
      end
      if (cmd.rng_gap) begin
         x_in = a_ff + 1'b1;
         c_in = '0;
         last_in = b_ff - 1'b1;
         gap_done_in = 1'b1;
      end
      if (adv) begin
         if (c_last) begin
            c_in = '0;
            x_in = x_ff + 1'b1;
         end else begin
            c_in = c_ff + 1'b1;
         end
      end

      ya_in = cmd.rd_b ? tab_q_ff : ya_ff;
      prod_in = cmd.mul ? prod_c : prod_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (cmd.div_ld) begin
         neg_in = prod_ff[PW-1];
         dvd_in = prod_ff[PW-1] ? PW'(-prod_ff) : PW'(prod_ff);
         rem_in = '0;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = ge ? CW'(rem_s - {1'b0, span}) : CW'(rem_s);
         dvd_in = {dvd_ff[PW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_mark_in  = rsp_mark_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = (op_ff == cgf_pkg::OP_READ && idx_ok) ? tab_q_ff : 16'h0000;
         rsp_mark_in  = (op_ff == cgf_pkg::OP_READ && idx_ok) ? mark_q_ff : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (t_we) tab_mem[t_waddr] <= t_wdata;
      if (t_re) tab_q_ff <= tab_mem[t_raddr];
      if (m_we) mark_mem[m_waddr] <= m_wdata;
      if (m_re) mark_q_ff <= mark_mem[m_raddr];
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      ch_ff <= ch_in;
      col_ff <= col_in;
      val_ff <= val_in;
      j_ff <= j_in;
      prev_ff <= prev_in;
      a_ff <= a_in;
      b_ff <= b_in;
      x_ff <= x_in;
      c_ff <= c_in;
      last_ff <= last_in;
      have_prev_ff <= have_prev_in;
      lead_ff <= lead_in;
      gap_done_ff <= gap_done_in;
      ya_ff <= ya_in;
      prod_ff <= prod_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_mark_ff <= rsp_mark_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      sts.op        = op_ff;
      sts.mark      = mark_q_ff;
      sts.have_prev = have_prev_ff;
      sts.lead      = lead_ff;
      sts.gap_ne    = (b_ff != a_ff + 1'b1) && !gap_done_ff;
      sts.j_last    = (j_ff == CW'(CHANNELS - 1));
      sts.clr_last  = (x_ff == CW'(CHANNELS - 1)) && c_last;
      sts.fill_last = (x_ff == last_ff) && c_last;
      sts.div_last  = (cnt_ff == NW'(PW - 1));
      sts.rsp_free  = ~rsp_valid_ff | rsp_ch.ready;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.read_value   = rsp_value_ff;
   assign rsp_ch.entry_marked = rsp_mark_ff;
   assign rsp_ch.done_res     = 1'b1;

endmodule

FILE: sv/cgf_ctrl.sv
// ----------------------------------------------------------------------------
// Calibration table gap fill: controller
// Sequences clearing passes, single-entry access and the fill scan.
// ----------------------------------------------------------------------------
module cgf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output cgf_pkg::cmd_type cmd,
   input  cgf_pkg::sts_type sts
);

   cgf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cgf_pkg::ST_START;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         cgf_pkg::ST_START: begin
            cmd.clr_start = 1'b1;
            state_in = cgf_pkg::ST_BOOT;
         end
         cgf_pkg::ST_BOOT: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = cgf_pkg::ST_IDLE;
         end
         cgf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in = cgf_pkg::ST_DECODE;
            end
         end
         cgf_pkg::ST_DECODE: begin
            case (sts.op)
               cgf_pkg::OP_WRITE: begin
                  cmd.wr_req = 1'b1;
                  state_in = cgf_pkg::ST_RESP;
               end
               cgf_pkg::OP_READ: begin
                  cmd.rd_issue = 1'b1;
                  state_in = cgf_pkg::ST_RESP;
               end
               cgf_pkg::OP_CLEAR: begin
                  cmd.clr_start = 1'b1;
                  state_in = cgf_pkg::ST_CLEAR;
               end
               default: begin
                  cmd.scan_init = 1'b1;
                  state_in = cgf_pkg::ST_SCAN_RD;
               end
            endcase
         end
         cgf_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = cgf_pkg::ST_RESP;
         end
         cgf_pkg::ST_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in = cgf_pkg::ST_SCAN_CHK;
         end
         cgf_pkg::ST_SCAN_CHK: begin
            if (sts.mark && sts.have_prev) begin
               cmd.seg_pair = 1'b1;
               state_in = cgf_pkg::ST_SEG;
            end else begin
               cmd.scan_take = sts.mark;
               if (sts.j_last) begin
                  state_in = cgf_pkg::ST_RESP;
               end else begin
                  cmd.scan_next = 1'b1;
                  state_in = cgf_pkg::ST_SCAN_RD;
               end
            end
         end
         cgf_pkg::ST_SEG: begin
            // The leading run before the first mark is filled once, then each gap.
            if (sts.lead) begin
               cmd.rng_lead = 1'b1;
               state_in = cgf_pkg::ST_RD_A;
            end else if (sts.gap_ne) begin
               cmd.rng_gap = 1'b1;
               state_in = cgf_pkg::ST_RD_A;
            end else begin
               cmd.seg_end = 1'b1;
               if (sts.j_last) begin
                  state_in = cgf_pkg::ST_RESP;
               end else begin
                  cmd.scan_next = 1'b1;
                  state_in = cgf_pkg::ST_SCAN_RD;
               end
            end
         end
         cgf_pkg::ST_RD_A: begin
            cmd.rd_a = 1'b1;
            state_in = cgf_pkg::ST_RD_B;
         end
         cgf_pkg::ST_RD_B: begin
            cmd.rd_b = 1'b1;
            state_in = cgf_pkg::ST_MUL;
         end
         cgf_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = cgf_pkg::ST_DIV_LD;
         end
         cgf_pkg::ST_DIV_LD: begin
            cmd.div_ld = 1'b1;
            state_in = cgf_pkg::ST_DIV;
         end
         cgf_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = cgf_pkg::ST_WR;
         end
         cgf_pkg::ST_WR: begin
            cmd.wr_fill = 1'b1;
            state_in = sts.fill_last ? cgf_pkg::ST_SEG : cgf_pkg::ST_RD_A;
         end
         cgf_pkg::ST_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = cgf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cgf_pkg::ST_START;
         end
      endcase
   end

endmodule

FILE: sv/calibration_table_gap_fill.sv
// ----------------------------------------------------------------------------
// Calibration table gap fill
// Per-channel gain table with mark bits, point writes, reads, clear and
// linear fill of gaps between marked channels and of the run before the first mark.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_ch (operation, channel, column, gain_value)
// and each produces exactly one response on rsp_ch (read_value, entry_marked,
// done_res). One request is worked on at a time; a new one is taken while the
// previous response still waits in the output register.
// Sequencing: a write or read passes through decode to the response state,
// a clear steps over all CHANNELS*COLUMNS entries. A fill scans the marks
// channel by channel and, per filled value, reads both ends, multiplies
// and runs a serial divider over PW = 18 + clog2(CHANNELS) bits (26 by default).
// After reset the block runs a clearing pass over the CHANNELS*COLUMNS table
// entries and the marks, with req_ch.ready low, and then comes up idle.
// When the receiver stalls, the response holds in its register; at most one
// further request is taken and completes once the register frees up.
// ----------------------------------------------------------------------------
module calibration_table_gap_fill #(
   parameter int CHANNELS = 256,
   parameter int COLUMNS  = 6
) (
   input logic       clock,
   input logic       reset,
   cgf_req_if.sink   req_ch,
   cgf_rsp_if.source rsp_ch
);

   cgf_pkg::cmd_type cmd;
   cgf_pkg::sts_type sts;
   logic             req_ready;

   cgf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   cgf_dp #(
      .CHANNELS (CHANNELS),
      .COLUMNS  (COLUMNS)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .sts    (sts),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   assign req_ch.ready = req_ready;

endmodule
